[src/owsd_pkg.sv]
`default_nettype none
package owsd_pkg;

	localparam int LevelW   = 10;
	localparam int LowW     = 11;
	localparam int TimeW    = 32;
	localparam int CircW    = 20;
	localparam int NumW     = 48;
	localparam int SpeedW   = 32;
	localparam int RevW     = 32;
	localparam int DistW    = 52;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 48;
	localparam int DivSteps = 48;
	localparam int DivCntW  = 6;

	localparam logic [TimeW-1:0] CalTicksReset = 32'd1200000000;
	localparam logic [CircW-1:0] CircReset     = 20'd6176;
	localparam logic [NumW-1:0]  NumReset      = 48'd370560000000;
	localparam logic [LowW-1:0]  LowReset      = 11'd1024;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_CAL_TICKS = 2'd0,
		CFG_CIRC      = 2'd1,
		CFG_NUMERATOR = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [LevelW-1:0] aft_level;
		logic [LevelW-1:0] fwd_level;
		logic [TimeW-1:0]  time_ticks;
	} owsd_in_t;

	typedef struct packed {
		logic                    calibrating;
		logic                    calibration_done;
		logic [LevelW-1:0]       aft_limit;
		logic [LevelW-1:0]       fwd_limit;
		logic                    motion_event;
		logic signed [RevW-1:0]  revolutions;
		logic signed [DistW-1:0] distance;
		logic [SpeedW-1:0]       speed;
		logic [SpeedW-1:0]       top_speed;
	} owsd_out_t;

	// sequencer program counter
	typedef enum logic [3:0] {
		S_WAIT  = 4'd0,
		S_MODE  = 4'd1,
		S_CAL   = 4'd2,
		S_EDGE  = 4'd3,
		S_DIV   = 4'd4,
		S_SPEED = 4'd5,
		S_MUL   = 4'd6,
		S_OUT   = 4'd7,
		S_HOLD  = 4'd8
	} step_t;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_LOAD  = 3'd1,
		OP_CAL   = 3'd2,
		OP_EDGE  = 3'd3,
		OP_DIV   = 3'd4,
		OP_SPEED = 3'd5,
		OP_MUL   = 3'd6,
		OP_OUT   = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT     = 3'd0,
		C_ALWAYS   = 3'd1,
		C_NO_INPUT = 3'd2,
		C_RUN      = 3'd3,
		C_NO_DIV   = 3'd4,
		C_DIV_MORE = 3'd5,
		C_OUT_FREE = 3'd6
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	// jump taken when cond holds, else fall through to the next step
	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		case (s)
			S_WAIT:  w = '{op: OP_LOAD,  cond: C_NO_INPUT, target: S_WAIT};
			S_MODE:  w = '{op: OP_NONE,  cond: C_RUN,      target: S_EDGE};
			S_CAL:   w = '{op: OP_CAL,   cond: C_ALWAYS,   target: S_MUL};
			S_EDGE:  w = '{op: OP_EDGE,  cond: C_NO_DIV,   target: S_MUL};
			S_DIV:   w = '{op: OP_DIV,   cond: C_DIV_MORE, target: S_DIV};
			S_SPEED: w = '{op: OP_SPEED, cond: C_NEXT,     target: S_WAIT};
			S_MUL:   w = '{op: OP_MUL,   cond: C_NEXT,     target: S_WAIT};
			S_OUT:   w = '{op: OP_OUT,   cond: C_OUT_FREE, target: S_WAIT};
			S_HOLD:  w = '{op: OP_NONE,  cond: C_ALWAYS,   target: S_OUT};
			default: w = '{op: OP_NONE,  cond: C_ALWAYS,   target: S_WAIT};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

[src/owsd_if.sv]
`default_nettype none
interface owsd_in_if;
	logic               valid;
	logic               ready;
	owsd_pkg::owsd_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface owsd_out_if;
	logic                valid;
	logic                ready;
	owsd_pkg::owsd_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/optical_wheel_speed_decoder_top.sv]
`default_nettype none
// channel   dir  payload                                         beat
// samples   in   aft_level, fwd_level, time_ticks                one per item
// results   out  calibrating .. top_speed (owsd_out_t)           one per item
// cfg       in   cfg_we, cfg_index, cfg_data                     one per write
//
// an item runs mode, cal or edge, multiply and output steps; a computed speed adds
// the divide and speed steps, where the restoring divider retires one quotient bit
// a cycle for all 48 quotient bits. a new sample is taken once the previous result
// sits in the output register, so results.ready low stalls only when it is still full.
// arst_n clears all control state and loads the register reset values.
module optical_wheel_speed_decoder_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	owsd_in_if.sink                            samples,
	owsd_out_if.source                         results,
	input  wire logic                          cfg_we,
	input  wire logic [owsd_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [owsd_pkg::CfgDataW-1:0] cfg_data
);

	// configuration
	logic [owsd_pkg::TimeW-1:0] cal_ticks_q;
	logic [owsd_pkg::CircW-1:0] circ_q;
	logic [owsd_pkg::NumW-1:0]  num_q;

	// sequencer
	owsd_pkg::step_t  pc_q, pc_d;
	owsd_pkg::ucode_t uc;
	logic [3:0]       pc_inc;
	logic             take;

	// state
	logic                          in_cal_q;
	logic [owsd_pkg::LowW-1:0]     aft_lo_q, fwd_lo_q;
	logic [owsd_pkg::LevelW-1:0]   aft_hi_q, fwd_hi_q;
	logic [owsd_pkg::LevelW-1:0]   aft_thr_q, fwd_thr_q;
	logic                          prev_fwd_q;
	logic [owsd_pkg::TimeW-1:0]    last_edge_q;
	logic                          have_edge_q;
	logic [owsd_pkg::RevW-1:0]     rev_q;
	logic [owsd_pkg::SpeedW-1:0]   speed_q, max_q;
	logic                          done_q, ev_q;
	logic [owsd_pkg::DivCntW-1:0]  div_cnt_q;

	// datapath
	owsd_pkg::owsd_in_t            smp_q;
	logic [owsd_pkg::TimeW-1:0]    den_q;
	logic [owsd_pkg::SpeedW-1:0]   rem_q;
	logic [owsd_pkg::NumW-1:0]     quo_q;
	logic [owsd_pkg::DistW-1:0]    dist_q;
	logic                          res_valid_q;
	owsd_pkg::owsd_out_t           res_data_q;

	logic                          accept, out_free;
	logic                          aft_over, fwd_over, fwd_edge, will_div, cal_end;
	logic [owsd_pkg::LowW-1:0]     aft_lo_n, fwd_lo_n;
	logic [owsd_pkg::LevelW-1:0]   aft_hi_n, fwd_hi_n;
	logic [owsd_pkg::LowW:0]       aft_sum, fwd_sum;
	logic [owsd_pkg::SpeedW:0]     shifted, diff;
	logic                          ge;
	logic [owsd_pkg::SpeedW-1:0]   speed_sat;
	logic signed [owsd_pkg::DistW:0] prod;
	owsd_pkg::owsd_out_t           res_n;

	assign uc       = owsd_pkg::ucode_rom(pc_q);
	assign pc_inc   = pc_q + 4'd1;
	assign samples.ready = (uc.op == owsd_pkg::OP_LOAD);
	assign accept   = samples.valid && samples.ready;
	assign out_free = !res_valid_q || results.ready;

	assign results.valid = res_valid_q;
	assign results.data  = res_data_q;

	// threshold compare and forward edge
	assign aft_over = smp_q.aft_level > aft_thr_q;
	assign fwd_over = smp_q.fwd_level > fwd_thr_q;
	assign fwd_edge = fwd_over != prev_fwd_q;
	assign will_div = fwd_edge && aft_over && have_edge_q;

	// calibration min/max and midpoint
	assign aft_lo_n = ({1'b0, smp_q.aft_level} < aft_lo_q) ? {1'b0, smp_q.aft_level} : aft_lo_q;
	assign fwd_lo_n = ({1'b0, smp_q.fwd_level} < fwd_lo_q) ? {1'b0, smp_q.fwd_level} : fwd_lo_q;
	assign aft_hi_n = (smp_q.aft_level > aft_hi_q) ? smp_q.aft_level : aft_hi_q;
	assign fwd_hi_n = (smp_q.fwd_level > fwd_hi_q) ? smp_q.fwd_level : fwd_hi_q;
	assign aft_sum  = {1'b0, aft_lo_n} + {2'b00, aft_hi_n};
	assign fwd_sum  = {1'b0, fwd_lo_n} + {2'b00, fwd_hi_n};
	assign cal_end  = smp_q.time_ticks > cal_ticks_q;

	// one restoring divide step
	assign shifted = {rem_q, quo_q[owsd_pkg::NumW-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};
	assign speed_sat = (|quo_q[owsd_pkg::NumW-1:owsd_pkg::SpeedW]) ? '1
		: quo_q[owsd_pkg::SpeedW-1:0];

	assign prod = $signed(rev_q) * $signed({1'b0, circ_q});

	always_comb begin
		res_n.calibrating      = in_cal_q;
		res_n.calibration_done = done_q;
		res_n.aft_limit        = aft_thr_q;
		res_n.fwd_limit        = fwd_thr_q;
		res_n.motion_event     = ev_q;
		res_n.revolutions      = $signed(rev_q);
		res_n.distance         = $signed(dist_q);
		res_n.speed            = speed_q;
		res_n.top_speed        = max_q;
	end

	// next step
	always_comb begin
		case (uc.cond)
			owsd_pkg::C_NEXT:     take = 1'b0;
			owsd_pkg::C_ALWAYS:   take = 1'b1;
			owsd_pkg::C_NO_INPUT: take = !samples.valid;
			owsd_pkg::C_RUN:      take = !in_cal_q;
			owsd_pkg::C_NO_DIV:   take = !will_div;
			owsd_pkg::C_DIV_MORE: take = div_cnt_q != owsd_pkg::DivCntW'(owsd_pkg::DivSteps - 1);
			owsd_pkg::C_OUT_FREE: take = out_free;
			default:              take = 1'b1;
		endcase
		pc_d = take ? uc.target : owsd_pkg::step_t'(pc_inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= owsd_pkg::S_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_ticks_q <= owsd_pkg::CalTicksReset;
			circ_q      <= owsd_pkg::CircReset;
			num_q       <= owsd_pkg::NumReset;
			in_cal_q    <= 1'b1;
			aft_lo_q    <= owsd_pkg::LowReset;
			fwd_lo_q    <= owsd_pkg::LowReset;
			aft_hi_q    <= '0;
			fwd_hi_q    <= '0;
			aft_thr_q   <= '0;
			fwd_thr_q   <= '0;
			prev_fwd_q  <= 1'b0;
			last_edge_q <= '0;
			have_edge_q <= 1'b0;
			rev_q       <= '0;
			speed_q     <= '0;
			max_q       <= '0;
			done_q      <= 1'b0;
			ev_q        <= 1'b0;
			div_cnt_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (owsd_pkg::cfg_idx_t'(cfg_index))
					owsd_pkg::CFG_CAL_TICKS: cal_ticks_q <= cfg_data[owsd_pkg::TimeW-1:0];
					owsd_pkg::CFG_CIRC:      circ_q <= cfg_data[owsd_pkg::CircW-1:0];
					owsd_pkg::CFG_NUMERATOR: num_q <= cfg_data[owsd_pkg::NumW-1:0];
					default: ;
				endcase
			end
			// a new beat may replace the one leaving in the same cycle
			if (uc.op == owsd_pkg::OP_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && results.ready) begin
				res_valid_q <= 1'b0;
			end
			case (uc.op)
				owsd_pkg::OP_LOAD: begin
					if (accept) begin
						done_q <= 1'b0;
						ev_q   <= 1'b0;
					end
				end
				owsd_pkg::OP_CAL: begin
					aft_lo_q <= aft_lo_n;
					fwd_lo_q <= fwd_lo_n;
					aft_hi_q <= aft_hi_n;
					fwd_hi_q <= fwd_hi_n;
					if (cal_end) begin
						aft_thr_q <= aft_sum[owsd_pkg::LevelW:1];
						fwd_thr_q <= fwd_sum[owsd_pkg::LevelW:1];
						in_cal_q  <= 1'b0;
						done_q    <= 1'b1;
					end
				end
				owsd_pkg::OP_EDGE: begin
					div_cnt_q <= '0;
					if (fwd_edge) begin
						prev_fwd_q  <= fwd_over;
						last_edge_q <= smp_q.time_ticks;
						have_edge_q <= 1'b1;
						if (aft_over) begin
							rev_q <= fwd_over ? rev_q + owsd_pkg::RevW'(1)
								: rev_q - owsd_pkg::RevW'(1);
						end
					end
				end
				owsd_pkg::OP_DIV: begin
					div_cnt_q <= div_cnt_q + owsd_pkg::DivCntW'(1);
				end
				owsd_pkg::OP_SPEED: begin
					speed_q <= speed_sat;
					if (speed_sat > max_q) begin
						max_q <= speed_sat;
					end
					ev_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (uc.op)
			owsd_pkg::OP_LOAD: begin
				if (accept) begin
					smp_q <= samples.data;
				end
			end
			owsd_pkg::OP_EDGE: begin
				// period uses the edge time before this edge updates it
				den_q <= smp_q.time_ticks - last_edge_q;
				rem_q <= '0;
				quo_q <= num_q;
			end
			owsd_pkg::OP_DIV: begin
				rem_q <= ge ? diff[owsd_pkg::SpeedW-1:0] : shifted[owsd_pkg::SpeedW-1:0];
				quo_q <= {quo_q[owsd_pkg::NumW-2:0], ge};
			end
			owsd_pkg::OP_MUL: begin
				dist_q <= prod[owsd_pkg::DistW-1:0];
			end
			owsd_pkg::OP_OUT: begin
				if (out_free) begin
					res_data_q <= res_n;
				end
			end
			default: ;
		endcase
	end

	a_done_ends_cal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_data_q.calibration_done |-> !res_data_q.calibrating)
		else $error("calibration_done while still calibrating");

	a_event_after_cal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_data_q.motion_event |-> !res_data_q.calibrating)
		else $error("motion event during calibration");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == owsd_pkg::S_SPEED |-> div_cnt_q == owsd_pkg::DivCntW'(owsd_pkg::DivSteps))
		else $error("divider did not run its full length");

	a_out_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == owsd_pkg::S_OUT && out_free |=> pc_q == owsd_pkg::S_WAIT && res_valid_q)
		else $error("result not posted before next sample");

	a_ready_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pc_q == owsd_pkg::S_MODE)
		else $error("sample accepted outside the wait step");

endmodule
`default_nettype wire
